@@ design/nrbo_pkg.sv @@
// Shared types and constants of the NV12 rectangle border overlay.
package nrbo_pkg;

  // Width of pixel coordinates and band bounds; covers every frame size up to 8192.
  localparam int POS_W = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_RGB     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_WIDTH = 3'd7;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [11:0] rect_left;
    logic [11:0] rect_top;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [23:0] fill_rgb;
    logic [7:0]  border_width;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             chroma;
    logic             last;
  } pos_t;

endpackage

@@ design/nrbo_position.sv @@
// Column, row and plane counters that place each byte of the NV12 stream.
module nrbo_position
  import nrbo_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic advance,
  input  logic start,
  output pos_t pos
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [POS_W-1:0] W_TOP = POS_W'(MAX_WIDTH & ~1);
  localparam logic [POS_W-1:0] H_TOP = POS_W'(MAX_HEIGHT & ~1);
  localparam logic [POS_W-1:0] MIN_SIZE = POS_W'(2);

  logic [XW-1:0] col, col_next, cur_col;
  logic [YW-1:0] row, row_next, cur_row;
  logic chroma, chroma_next, cur_chroma;
  logic last;
  logic [POS_W-1:0] w_even, h_even, w, h, limit, col_inc, row_inc;

  always_comb begin
    cur_col    = start ? '0 : col;
    cur_row    = start ? '0 : row;
    cur_chroma = start ? 1'b0 : chroma;

    w_even = POS_W'({cfg.frame_width[12:1], 1'b0});
    h_even = POS_W'({cfg.frame_height[12:1], 1'b0});
    if (w_even < MIN_SIZE) begin
      w = MIN_SIZE;
    end else if (w_even > W_TOP) begin
      w = W_TOP;
    end else begin
      w = w_even;
    end
    if (h_even < MIN_SIZE) begin
      h = MIN_SIZE;
    end else if (h_even > H_TOP) begin
      h = H_TOP;
    end else begin
      h = h_even;
    end

    col_inc = POS_W'(cur_col) + POS_W'(1);
    row_inc = POS_W'(cur_row) + POS_W'(1);
    limit   = cur_chroma ? (h >> 1) : h;

    col_next    = XW'(col_inc);
    row_next    = cur_row;
    chroma_next = cur_chroma;
    last        = 1'b0;
    if (col_inc >= w) begin
      col_next = '0;
      if (row_inc >= limit) begin
        row_next    = '0;
        last        = cur_chroma;
        chroma_next = !cur_chroma;
      end else begin
        row_next = YW'(row_inc);
      end
    end

    pos.col    = POS_W'(cur_col);
    pos.row    = POS_W'(cur_row);
    pos.chroma = cur_chroma;
    pos.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      chroma <= 1'b0;
    end else if (advance) begin
      col    <= col_next;
      row    <= row_next;
      chroma <= chroma_next;
    end
  end

endmodule

@@ design/nrbo_color.sv @@
// RGB to YUV conversion of the fill color in Q16 fixed point, clamped to 0..255.
module nrbo_color (
  input  logic [23:0] rgb,
  output logic [7:0]  fill_y,
  output logic [7:0]  fill_u,
  output logic [7:0]  fill_v
);

  localparam int SW = 26;
  localparam logic signed [SW-1:0] KY_R = 26'sd19595;
  localparam logic signed [SW-1:0] KY_G = 26'sd38470;
  localparam logic signed [SW-1:0] KY_B = 26'sd7471;
  localparam logic signed [SW-1:0] KU_R = 26'sd11056;
  localparam logic signed [SW-1:0] KU_G = 26'sd21712;
  localparam logic signed [SW-1:0] KU_B = 26'sd32768;
  localparam logic signed [SW-1:0] KV_R = 26'sd32768;
  localparam logic signed [SW-1:0] KV_G = 26'sd27440;
  localparam logic signed [SW-1:0] KV_B = 26'sd5328;
  localparam logic signed [SW-1:0] OFFSET = 26'sd8388608;

  logic signed [SW-1:0] r, g, b, sum_y, sum_u, sum_v;

  function automatic logic [7:0] clamp_q16(input logic signed [SW-1:0] s);
    logic [7:0] res;
    if (s < 0) begin
      res = 8'd0;
    end else if (s[SW-1:16] > 10'd255) begin
      res = 8'd255;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

  always_comb begin
    r = SW'(rgb[23:16]);
    g = SW'(rgb[15:8]);
    b = SW'(rgb[7:0]);
    sum_y = KY_R * r + KY_G * g + KY_B * b;
    sum_u = KU_B * b - KU_R * r - KU_G * g + OFFSET;
    sum_v = KV_R * r - KV_G * g - KV_B * b + OFFSET;
    fill_y = clamp_q16(sum_y);
    fill_u = clamp_q16(sum_u);
    fill_v = clamp_q16(sum_v);
  end

endmodule

@@ design/nrbo_band.sv @@
// Decides whether a luma byte, or any of the four pixels of a chroma pair, lies in the border.
module nrbo_band
  import nrbo_pkg::*;
(
  input  cfg_t cfg,
  input  pos_t pos,
  output logic hit
);

  logic [POS_W-1:0] x0, y0, x1, y1;

  function automatic logic in_band(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                   input cfg_t c);
    logic [POS_W-1:0] left, top, xe, ye, bw;
    logic in_rect, near;
    left    = POS_W'(c.rect_left);
    top     = POS_W'(c.rect_top);
    bw      = POS_W'(c.border_width);
    xe      = left + POS_W'(c.rect_width);
    ye      = top + POS_W'(c.rect_height);
    in_rect = (x >= left) && (x < xe) && (y >= top) && (y < ye);
    near    = (x < left + bw) || (x + bw >= xe) || (y < top + bw) || (y + bw >= ye);
    return in_rect && near;
  endfunction

  always_comb begin
    x0 = pos.chroma ? {pos.col[POS_W-1:1], 1'b0} : pos.col;
    y0 = pos.chroma ? {pos.row[POS_W-2:0], 1'b0} : pos.row;
    x1 = x0 + POS_W'(1);
    y1 = y0 + POS_W'(1);
    hit = in_band(x0, y0, cfg) ||
          (pos.chroma && (in_band(x1, y0, cfg) || in_band(x0, y1, cfg) ||
                          in_band(x1, y1, cfg)));
  end

endmodule

@@ design/nv12_rect_border_overlay_unit.sv @@
// Top level of the NV12 rectangle border overlay: configuration, input stage and output stage.
// The unit takes one byte of an NV12 frame per clock while s_tready is high (the whole Y plane,
// then the interleaved UV plane) and returns it either unchanged or replaced by the Y, U or V
// value of the border color. Each byte passes an input register and then an output register
// before its result is presented. While a result waits on m_tready, one further byte can still
// enter the input register; s_tready then stays low until the output moves on. The position
// counters advance on every accepted byte, and s_tuser restarts them at the top of the Y plane.
// m_tlast marks the last chroma byte of each frame. Configuration writes are meant for times
// when no byte is in flight.
module nv12_rect_border_overlay_unit
  import nrbo_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // pixel_byte
  input  logic                 s_tuser,   // frame_start
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_byte
  output logic                 m_tuser,   // replaced
  output logic                 m_tlast    // frame_end
);

  cfg_t cfg;
  pos_t pos, s1_pos;
  logic s1_valid, out_free, s1_move, in_acc, hit;
  logic [7:0] s1_pix, fill_y, fill_u, fill_v, fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 13'd1920;
      cfg.frame_height <= 13'd1080;
      cfg.rect_left    <= '0;
      cfg.rect_top     <= '0;
      cfg.rect_width   <= '0;
      cfg.rect_height  <= '0;
      cfg.fill_rgb     <= 24'd255;
      cfg.border_width <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[12:0];
        REG_RECT_LEFT:    cfg.rect_left    <= cfg_data[11:0];
        REG_RECT_TOP:     cfg.rect_top     <= cfg_data[11:0];
        REG_RECT_WIDTH:   cfg.rect_width   <= cfg_data[12:0];
        REG_RECT_HEIGHT:  cfg.rect_height  <= cfg_data[12:0];
        REG_FILL_RGB:     cfg.fill_rgb     <= cfg_data;
        REG_BORDER_WIDTH: cfg.border_width <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;
  assign in_acc   = s_tvalid && s_tready;

  nrbo_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_position (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .advance(in_acc),
    .start  (s_tuser),
    .pos    (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix <= s_tdata;
      s1_pos <= pos;
    end
  end

  nrbo_band u_band (
    .cfg(cfg),
    .pos(s1_pos),
    .hit(hit)
  );

  nrbo_color u_color (
    .rgb   (cfg.fill_rgb),
    .fill_y(fill_y),
    .fill_u(fill_u),
    .fill_v(fill_v)
  );

  always_comb begin
    if (!s1_pos.chroma) begin
      fill = fill_y;
    end else if (s1_pos.col[0]) begin
      fill = fill_v;
    end else begin
      fill = fill_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= hit ? fill : s1_pix;
      m_tuser <= hit;
      m_tlast <= s1_pos.last;
    end
  end

  a_start_resets_position: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=>
      (s1_valid && !s1_pos.chroma && s1_pos.col == '0 && s1_pos.row == '0))
    else $error("frame start did not restart the position counters");

  a_last_is_chroma: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pos.last) |-> s1_pos.chroma)
    else $error("frame end marked on a luma byte");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_pix) && $stable(s1_pos)))
    else $error("input stage lost or changed a stalled item");

endmodule
